FILE: src/ra_mutex_pkg.sv
`timescale 1ns / 1ps

package ra_mutex_pkg;

  localparam int MAX_PEERS_DEF     = 16;
  localparam int NODE_ID_SPACE_DEF = 128;

  // Largest id that the seven-bit peer field can carry, plus one
  localparam int ID_FIELD_SPAN = 128;

  localparam logic [2:0] CMD_ADD_PEER = 3'd0;
  localparam logic [2:0] CMD_WANT     = 3'd1;
  localparam logic [2:0] CMD_REQUEST  = 3'd2;
  localparam logic [2:0] CMD_REPLY    = 3'd3;
  localparam logic [2:0] CMD_RELEASE  = 3'd4;

  localparam logic [1:0] ACT_REQUEST = 2'd0;
  localparam logic [1:0] ACT_REPLY   = 2'd1;
  localparam logic [1:0] ACT_ENTER   = 2'd2;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  localparam logic [15:0] SEQ_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  command;
    logic [6:0]  peer_id;
    logic [15:0] seq_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  dest_node;
    logic [15:0] out_seq;
    logic        last;
  } out_item_t;

endpackage

FILE: src/ra_mutex_peer_ram.sv
`timescale 1ns / 1ps

module ra_mutex_peer_ram #(
  parameter int DEPTH  = ra_mutex_pkg::MAX_PEERS_DEF,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [6:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [6:0]        rdata
);

  logic [6:0] mem [DEPTH];
  logic [6:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/ra_mutex_out_reg.sv
`timescale 1ns / 1ps

module ra_mutex_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ra_mutex_pkg::out_item_t push_item,
  output logic                   push_ok,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ra_mutex_pkg::out_item_t out_data
);

  logic                    valid_r;
  ra_mutex_pkg::out_item_t data_r;

  assign push_ok   = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_item;
    end
  end

endmodule

FILE: src/ra_mutex_ctrl.sv
`timescale 1ns / 1ps

module ra_mutex_ctrl #(
  parameter int MAX_PEERS     = ra_mutex_pkg::MAX_PEERS_DEF,
  parameter int NODE_ID_SPACE = ra_mutex_pkg::NODE_ID_SPACE_DEF,
  parameter int IDX_W         = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ra_mutex_pkg::in_item_t  in_data,
  input  logic                    cfg_we,
  input  logic [6:0]              cfg_wdata,
  output logic                    ram_we,
  output logic [IDX_W-1:0]        ram_waddr,
  output logic [6:0]              ram_wdata,
  output logic                    ram_re,
  output logic [IDX_W-1:0]        ram_raddr,
  input  logic [6:0]              ram_rdata,
  output logic                    push,
  output ra_mutex_pkg::out_item_t push_item,
  input  logic                    push_ok
);

  localparam int CNT_W     = $clog2(MAX_PEERS + 1);
  localparam int DEF_DEPTH = (NODE_ID_SPACE < ra_mutex_pkg::ID_FIELD_SPAN) ?
                             NODE_ID_SPACE : ra_mutex_pkg::ID_FIELD_SPAN;
  localparam int DEF_W     = $clog2(DEF_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WALK = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [2:0]             cmd_r;
  logic [6:0]             peer_r;
  logic [15:0]            seq_r;
  logic [6:0]             own_id_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [15:0]            own_seq_r, own_seq_nxt;
  logic [15:0]            hi_seq_r, hi_seq_nxt;
  logic [CNT_W-1:0]       pend_r, pend_nxt;
  logic                   req_r, req_nxt;
  logic                   ins_r, ins_nxt;
  logic                   bcast_r, bcast_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   held_v_r, held_v_nxt;
  logic [6:0]             held_r, held_nxt;
  logic                   chk_r, chk_nxt;

  // Deferred flag per node id. Only listed ids are ever read, and adding an
  // id clears its flag, so the memory needs no clearing after reset or release.
  logic                   def_mem [DEF_DEPTH];
  logic                   def_q;
  logic                   def_we;
  logic [DEF_W-1:0]       def_waddr;
  logic                   def_wdata;
  logic                   def_re;

  logic                   accept;
  logic                   id_ok;
  logic                   p_ok;
  logic                   qual;
  logic [CNT_W-1:0]       idx_inc;
  logic                   more;
  logic [15:0]            hi_inc;
  logic                   defer;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  assign id_ok   = (32'(peer_r) < 32'(NODE_ID_SPACE));
  assign p_ok    = (32'(ram_rdata) < 32'(NODE_ID_SPACE));
  assign qual    = bcast_r || (p_ok && def_q);
  assign idx_inc = idx_r + CNT_W'(1);
  assign more    = (idx_inc < count_r);
  assign hi_inc  = (hi_seq_r != ra_mutex_pkg::SEQ_MAX) ? hi_seq_r + 16'd1 : hi_seq_r;
  // Priority: the lower (number, id) pair wins
  assign defer   = req_r && ((seq_r > own_seq_r) ||
                             ((seq_r == own_seq_r) && (peer_r > own_id_r)));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    own_seq_nxt = own_seq_r;
    hi_seq_nxt  = hi_seq_r;
    pend_nxt    = pend_r;
    req_nxt     = req_r;
    ins_nxt     = ins_r;
    bcast_nxt   = bcast_r;
    idx_nxt     = idx_r;
    held_v_nxt  = held_v_r;
    held_nxt    = held_r;
    chk_nxt     = chk_r;
    def_we      = 1'b0;
    def_waddr   = peer_r[DEF_W-1:0];
    def_wdata   = 1'b0;
    def_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = count_r[IDX_W-1:0];
    ram_wdata   = peer_r;
    ram_re      = 1'b0;
    ram_raddr   = idx_inc[IDX_W-1:0];
    push        = 1'b0;
    push_item   = '{action: ra_mutex_pkg::ACT_IGNORED, dest_node: 7'd0,
                    out_seq: 16'd0, last: 1'b1};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // A single result waits here for push_ok; other branches move on without it
        unique case (cmd_r)
          ra_mutex_pkg::CMD_ADD_PEER: begin
            if (!id_ok || (32'(count_r) >= 32'(MAX_PEERS))) begin
              push = 1'b1;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              def_we    = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          ra_mutex_pkg::CMD_WANT: begin
            if (req_r || ins_r) begin
              push = 1'b1;
            end else if (count_r == '0) begin
              push_item.action = ra_mutex_pkg::ACT_ENTER;
              push = 1'b1;
              if (push_ok) begin
                req_nxt     = 1'b1;
                ins_nxt     = 1'b1;
                hi_seq_nxt  = hi_inc;
                own_seq_nxt = hi_inc;
                pend_nxt    = count_r;
              end
            end else begin
              req_nxt     = 1'b1;
              hi_seq_nxt  = hi_inc;
              own_seq_nxt = hi_inc;
              pend_nxt    = count_r;
              bcast_nxt   = 1'b1;
              idx_nxt     = '0;
              held_v_nxt  = 1'b0;
              ram_re      = 1'b1;
              ram_raddr   = '0;
              state_nxt   = ST_WALK;
            end
          end
          ra_mutex_pkg::CMD_REQUEST: begin
            if (!id_ok) begin
              push = 1'b1;
            end else begin
              if (seq_r > hi_seq_r) begin
                hi_seq_nxt = seq_r;
              end
              if (defer) begin
                def_we    = 1'b1;
                def_wdata = 1'b1;
                state_nxt = ST_IDLE;
              end else begin
                push_item.action    = ra_mutex_pkg::ACT_REPLY;
                push_item.dest_node = peer_r;
                push = 1'b1;
                if (!push_ok) begin
                  hi_seq_nxt = hi_seq_r;
                end
              end
            end
          end
          ra_mutex_pkg::CMD_REPLY: begin
            if (!id_ok || !req_r || ins_r || (pend_r == '0)) begin
              push = 1'b1;
            end else if (pend_r == CNT_W'(1)) begin
              push_item.action = ra_mutex_pkg::ACT_ENTER;
              push = 1'b1;
              if (push_ok) begin
                pend_nxt = '0;
                ins_nxt  = 1'b1;
              end
            end else begin
              pend_nxt  = pend_r - CNT_W'(1);
              state_nxt = ST_IDLE;
            end
          end
          ra_mutex_pkg::CMD_RELEASE: begin
            if (!ins_r) begin
              push = 1'b1;
            end else begin
              ins_nxt = 1'b0;
              req_nxt = 1'b0;
              if (count_r == '0) begin
                state_nxt = ST_IDLE;
              end else begin
                bcast_nxt  = 1'b0;
                idx_nxt    = '0;
                held_v_nxt = 1'b0;
                chk_nxt    = 1'b0;
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_nxt  = ST_WALK;
              end
            end
          end
          default: begin
            push = 1'b1;
          end
        endcase
        if (push) begin
          push = push_ok;
          if (push_ok) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_WALK: begin
        // Keep one message back so the final one can carry last
        push_item.action    = bcast_r ? ra_mutex_pkg::ACT_REQUEST : ra_mutex_pkg::ACT_REPLY;
        push_item.dest_node = held_r;
        push_item.out_seq   = bcast_r ? own_seq_r : 16'd0;
        push_item.last      = 1'b0;
        if (!bcast_r && !chk_r) begin
          // Fetch the entry's deferred flag before answering it
          def_re  = 1'b1;
          chk_nxt = 1'b1;
        end else if (!(qual && held_v_r && !push_ok)) begin
          chk_nxt = 1'b0;
          if (qual) begin
            push       = held_v_r;
            held_v_nxt = 1'b1;
            held_nxt   = ram_rdata;
            if (!bcast_r) begin
              def_we    = 1'b1;
              def_waddr = ram_rdata[DEF_W-1:0];
            end
          end
          idx_nxt = idx_inc;
          if (more) begin
            ram_re = 1'b1;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        push_item.action    = bcast_r ? ra_mutex_pkg::ACT_REQUEST : ra_mutex_pkg::ACT_REPLY;
        push_item.dest_node = held_r;
        push_item.out_seq   = bcast_r ? own_seq_r : 16'd0;
        push_item.last      = 1'b1;
        if (!held_v_r || push_ok) begin
          push       = held_v_r;
          held_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      own_id_r  <= 7'd0;
      count_r   <= '0;
      own_seq_r <= 16'd0;
      hi_seq_r  <= 16'd0;
      pend_r    <= '0;
      req_r     <= 1'b0;
      ins_r     <= 1'b0;
      bcast_r   <= 1'b0;
      idx_r     <= '0;
      held_v_r  <= 1'b0;
      chk_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) begin
        own_id_r <= cfg_wdata;
      end
      count_r   <= count_nxt;
      own_seq_r <= own_seq_nxt;
      hi_seq_r  <= hi_seq_nxt;
      pend_r    <= pend_nxt;
      req_r     <= req_nxt;
      ins_r     <= ins_nxt;
      bcast_r   <= bcast_nxt;
      idx_r     <= idx_nxt;
      held_v_r  <= held_v_nxt;
      chk_r     <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (accept) begin
      cmd_r  <= in_data.command;
      peer_r <= in_data.peer_id;
      seq_r  <= in_data.seq_number;
    end
  end

  always_ff @(posedge clk) begin
    if (def_we) begin
      def_mem[def_waddr] <= def_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (def_re) begin
      def_q <= def_mem[ram_rdata[DEF_W-1:0]];
    end
  end

endmodule

FILE: src/ricart_agrawala_mutex_node.sv
`timescale 1ns / 1ps

// One node of Ricart-Agrawala mutual exclusion. Each request carries a command
// (add peer, want section, request received, reply received, release) and
// yields zero or more messages on the out channel, the final one of a run
// flagged by last. The node takes one request at a time: in_stall is high from
// the cycle after acceptance until the request is finished. Add, received
// request, received reply and rejected commands finish in the execute state;
// want and release walk a non-empty peer list through the peer RAM. Want sends
// one request per cycle while the output register can take it; release first
// reads each entry's deferred flag from the flag memory before it answers that
// entry. Every message passes through one output register, which out_stall
// holds. own_node_id is written through cfg_we / cfg_wdata; the user must do so
// only while the node is idle, since the node itself does not enforce this.
module ricart_agrawala_mutex_node #(
  parameter int MAX_PEERS     = ra_mutex_pkg::MAX_PEERS_DEF,
  parameter int NODE_ID_SPACE = ra_mutex_pkg::NODE_ID_SPACE_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ra_mutex_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ra_mutex_pkg::out_item_t out_data,
  input  logic                    cfg_we,
  input  logic [6:0]              cfg_wdata
);

  localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [6:0]              ram_wdata;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [6:0]              ram_rdata;
  logic                    push;
  ra_mutex_pkg::out_item_t push_item;
  logic                    push_ok;

  ra_mutex_ctrl #(
    .MAX_PEERS     (MAX_PEERS),
    .NODE_ID_SPACE (NODE_ID_SPACE),
    .IDX_W         (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .push      (push),
    .push_item (push_item),
    .push_ok   (push_ok)
  );

  ra_mutex_peer_ram #(
    .DEPTH  (MAX_PEERS),
    .ADDR_W (IDX_W)
  ) u_peer_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ra_mutex_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .push_ok   (push_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: verif/ricart_agrawala_mutex_node_checker.sv
`timescale 1ns / 1ps

module ricart_agrawala_mutex_node_checker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  ra_mutex_pkg::in_item_t  in_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  ra_mutex_pkg::out_item_t out_data,
  input  logic                    cfg_we,
  input  logic [6:0]              cfg_wdata,
  output int                      fail_count,
  output int                      expected_count
);

  // Shadow copy of the node
  logic [6:0]                                 my_id;
  logic [6:0]                                 peer_tbl [ra_mutex_pkg::MAX_PEERS_DEF];
  int                                         peer_num;
  logic [ra_mutex_pkg::NODE_ID_SPACE_DEF-1:0] defer_bits;
  logic [15:0]                                my_seq;
  logic [15:0]                                top_seq;
  int                                         awaiting;
  logic                                       want_flag;
  logic                                       in_cs;

  ra_mutex_pkg::out_item_t pending_msgs [$];
  int                      errors = 0;

  function automatic ra_mutex_pkg::out_item_t make_msg(logic [1:0] act, logic [6:0] dest,
                                                        logic [15:0] seq);
    ra_mutex_pkg::out_item_t m;
    m.action    = act;
    m.dest_node = dest;
    m.out_seq   = seq;
    m.last      = 1'b0;
    return m;
  endfunction

  task automatic predict_messages(input ra_mutex_pkg::in_item_t req);
    ra_mutex_pkg::out_item_t run [$];
    logic                    id_ok;
    logic [6:0]              p;
    begin
      id_ok = int'(req.peer_id) < ra_mutex_pkg::NODE_ID_SPACE_DEF;
      case (req.command)
        ra_mutex_pkg::CMD_ADD_PEER: begin
          if (!id_ok || peer_num >= ra_mutex_pkg::MAX_PEERS_DEF) begin
            run.push_back(make_msg(ra_mutex_pkg::ACT_IGNORED, '0, '0));
          end else begin
            peer_tbl[peer_num] = req.peer_id;
            peer_num++;
            defer_bits[req.peer_id] = 1'b0;
          end
        end
        ra_mutex_pkg::CMD_WANT: begin
          if (want_flag || in_cs) begin
            run.push_back(make_msg(ra_mutex_pkg::ACT_IGNORED, '0, '0));
          end else begin
            want_flag = 1'b1;
            if (top_seq != ra_mutex_pkg::SEQ_MAX) top_seq++;
            my_seq   = top_seq;
            awaiting = peer_num;
            if (peer_num == 0) begin
              in_cs = 1'b1;
              run.push_back(make_msg(ra_mutex_pkg::ACT_ENTER, '0, '0));
            end else begin
              for (int i = 0; i < peer_num; i++)
                run.push_back(make_msg(ra_mutex_pkg::ACT_REQUEST, peer_tbl[i], my_seq));
            end
          end
        end
        ra_mutex_pkg::CMD_REQUEST: begin
          if (!id_ok) begin
            run.push_back(make_msg(ra_mutex_pkg::ACT_IGNORED, '0, '0));
          end else begin
            if (req.seq_number > top_seq) top_seq = req.seq_number;
            // hold the reply while our own request has priority
            if (want_flag && (req.seq_number > my_seq ||
                (req.seq_number == my_seq && req.peer_id > my_id))) begin
              defer_bits[req.peer_id] = 1'b1;
            end else begin
              run.push_back(make_msg(ra_mutex_pkg::ACT_REPLY, req.peer_id, '0));
            end
          end
        end
        ra_mutex_pkg::CMD_REPLY: begin
          if (!id_ok || !want_flag || in_cs || awaiting == 0) begin
            run.push_back(make_msg(ra_mutex_pkg::ACT_IGNORED, '0, '0));
          end else begin
            awaiting--;
            if (awaiting == 0) begin
              in_cs = 1'b1;
              run.push_back(make_msg(ra_mutex_pkg::ACT_ENTER, '0, '0));
            end
          end
        end
        ra_mutex_pkg::CMD_RELEASE: begin
          if (!in_cs) begin
            run.push_back(make_msg(ra_mutex_pkg::ACT_IGNORED, '0, '0));
          end else begin
            in_cs     = 1'b0;
            want_flag = 1'b0;
            // answer each deferred listed peer once, then drop the rest
            for (int i = 0; i < peer_num; i++) begin
              p = peer_tbl[i];
              if (defer_bits[p]) begin
                defer_bits[p] = 1'b0;
                run.push_back(make_msg(ra_mutex_pkg::ACT_REPLY, p, '0));
              end
            end
            defer_bits = '0;
          end
        end
        default: run.push_back(make_msg(ra_mutex_pkg::ACT_IGNORED, '0, '0));
      endcase
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[k]) pending_msgs.push_back(run[k]);
    end
  endtask

  task automatic compare_message(input ra_mutex_pkg::out_item_t got);
    ra_mutex_pkg::out_item_t want;
    begin
      if (pending_msgs.size() == 0) begin
        $error("message with none expected: action %0d dest_node %0d out_seq %0d last %0d",
               got.action, got.dest_node, got.out_seq, got.last);
        errors++;
      end else begin
        want = pending_msgs.pop_front();
        if (got.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, got.action);
          errors++;
        end
        if (got.dest_node !== want.dest_node) begin
          $error("dest_node: expected %0d, got %0d", want.dest_node, got.dest_node);
          errors++;
        end
        if (got.out_seq !== want.out_seq) begin
          $error("out_seq: expected %0d, got %0d", want.out_seq, got.out_seq);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          errors++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      my_id      = '0;
      peer_num   = 0;
      defer_bits = '0;
      my_seq     = '0;
      top_seq    = '0;
      awaiting   = 0;
      want_flag  = 1'b0;
      in_cs      = 1'b0;
      pending_msgs.delete();
      foreach (peer_tbl[i]) peer_tbl[i] = '0;
    end else begin
      if (out_valid && !out_stall) compare_message(out_data);
      if (cfg_we) my_id = cfg_wdata;
      if (in_valid && !in_stall) predict_messages(in_data);
    end
    fail_count     <= errors;
    expected_count <= pending_msgs.size();
  end

endmodule

FILE: verif/ricart_agrawala_mutex_node_test.sv
`timescale 1ns / 1ps

module ricart_agrawala_mutex_node_test;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  ra_mutex_pkg::in_item_t  in_data;
  logic                    out_valid;
  logic                    out_stall;
  ra_mutex_pkg::out_item_t out_data;
  logic                    cfg_we;
  logic [6:0]              cfg_wdata;

  int fail_total;
  int expected_count;

  int          items_sent = 0;
  logic [6:0]  roster [$];
  logic [15:0] seq_hint = '0;
  bit          wide_seq = 1'b0;
  bit          calm = 1'b0;
  bit          rx_hold_req = 1'b0;
  bit          rx_hold_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ricart_agrawala_mutex_node dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ricart_agrawala_mutex_node_checker watcher (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_total),
    .expected_count (expected_count)
  );

  function automatic logic [6:0] any_id();
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [6:0] pick_peer();
    if (roster.size() > 0 && $urandom_range(0, 99) < 75)
      return roster[$urandom_range(0, roster.size() - 1)];
    return any_id();
  endfunction

  // keep sequence numbers near the node's own so that ties and both orders occur
  function automatic logic [15:0] pick_seq();
    int s;
    if (wide_seq) return 16'($urandom);
    s = int'(seq_hint) + int'($urandom_range(0, 6)) - 3;
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    return 16'(s);
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [6:0] peer,
                           input logic [15:0] seq);
    if (!calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {cmd, peer, seq};
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (cmd == ra_mutex_pkg::CMD_ADD_PEER && roster.size() < ra_mutex_pkg::MAX_PEERS_DEF)
      roster.push_back(peer);
    if (cmd == ra_mutex_pkg::CMD_WANT && seq_hint != ra_mutex_pkg::SEQ_MAX) seq_hint++;
    if (cmd == ra_mutex_pkg::CMD_REQUEST && seq > seq_hint) seq_hint = seq;
  endtask

  // drop valid, wait for every expected message, then let silent work finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_count != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_id(input logic [6:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic play_round();
    int owed;
    begin
      owed = roster.size();
      send_item(ra_mutex_pkg::CMD_WANT, any_id(), 16'($urandom));
      while (owed > 0) begin
        if ($urandom_range(0, 99) < 70) begin
          send_item(ra_mutex_pkg::CMD_REPLY, pick_peer(), 16'($urandom));
          owed--;
        end else if ($urandom_range(0, 9) == 0 &&
                     roster.size() < ra_mutex_pkg::MAX_PEERS_DEF) begin
          send_item(ra_mutex_pkg::CMD_ADD_PEER, any_id(), 16'($urandom));
        end else begin
          send_item(ra_mutex_pkg::CMD_REQUEST, pick_peer(), pick_seq());
        end
      end
      repeat ($urandom_range(0, 3))
        send_item(ra_mutex_pkg::CMD_REQUEST, pick_peer(), pick_seq());
      // now and then leave the section held
      if ($urandom_range(0, 9) != 0)
        send_item(ra_mutex_pkg::CMD_RELEASE, any_id(), 16'($urandom));
    end
  endtask

  task automatic scramble();
    send_item(3'($urandom_range(0, 7)), pick_peer(), pick_seq());
  endtask

  task automatic run_random(input int upto);
    while (items_sent < upto) begin
      if ($urandom_range(0, 99) < 65) play_round();
      else repeat ($urandom_range(1, 3)) scramble();
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !rx_hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold_done = 1'b1;
      end
      out_stall <= (!calm && $urandom_range(0, 99) < 18);
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_id(7'd64);

    // no peers yet: enter at once, then the busy and out-of-section cases
    send_item(ra_mutex_pkg::CMD_WANT, 7'd0, 16'd0);
    send_item(ra_mutex_pkg::CMD_WANT, 7'd0, 16'd0);
    send_item(ra_mutex_pkg::CMD_REQUEST, 7'd9, 16'd5);
    send_item(ra_mutex_pkg::CMD_REPLY, 7'd3, 16'd0);
    send_item(ra_mutex_pkg::CMD_RELEASE, 7'd0, 16'd0);
    send_item(ra_mutex_pkg::CMD_RELEASE, 7'd0, 16'd0);
    send_item(ra_mutex_pkg::CMD_REQUEST, 7'd127, 16'd2);
    send_item(ra_mutex_pkg::CMD_REPLY, 7'd1, 16'd0);
    send_item(3'd5, 7'd127, 16'hFFFF);
    send_item(3'd6, 7'd0, 16'h0000);
    send_item(3'd7, 7'd85, 16'hAAAA);
    send_item(ra_mutex_pkg::CMD_ADD_PEER, 7'd0, 16'd0);
    send_item(ra_mutex_pkg::CMD_ADD_PEER, 7'd127, 16'd0);
    send_item(ra_mutex_pkg::CMD_ADD_PEER, 7'd42, 16'd0);
    send_item(ra_mutex_pkg::CMD_ADD_PEER, 7'd42, 16'd0);
    send_item(ra_mutex_pkg::CMD_WANT, 7'd0, 16'd0);
    // ties broken by node id, later numbers deferred, an unlisted sender
    send_item(ra_mutex_pkg::CMD_REQUEST, 7'd42, 16'd6);
    send_item(ra_mutex_pkg::CMD_REQUEST, 7'd127, 16'd6);
    send_item(ra_mutex_pkg::CMD_REQUEST, 7'd0, 16'd7);
    send_item(ra_mutex_pkg::CMD_REQUEST, 7'd99, 16'd8);
    send_item(ra_mutex_pkg::CMD_REQUEST, 7'd11, 16'd9);
    send_item(ra_mutex_pkg::CMD_ADD_PEER, 7'd11, 16'd0);
    repeat (4) send_item(ra_mutex_pkg::CMD_REPLY, pick_peer(), 16'd0);
    send_item(ra_mutex_pkg::CMD_REPLY, 7'd0, 16'd0);
    send_item(ra_mutex_pkg::CMD_RELEASE, 7'd0, 16'd0);

    settle();
    write_id(7'd127);
    seq_hint = 16'd10;
    while (items_sent < 280) begin
      calm = (items_sent >= 110 && items_sent < 170);
      if (items_sent >= 200) rx_hold_req = 1'b1;
      if ($urandom_range(0, 99) < 65) play_round();
      else repeat ($urandom_range(1, 3)) scramble();
    end
    calm = 1'b0;

    settle();
    write_id(7'd0);
    wide_seq = 1'b1;
    // fill the list, one add past full, then pin the numbers at the top
    while (roster.size() < ra_mutex_pkg::MAX_PEERS_DEF)
      send_item(ra_mutex_pkg::CMD_ADD_PEER, any_id(), 16'($urandom));
    send_item(ra_mutex_pkg::CMD_ADD_PEER, any_id(), 16'($urandom));
    send_item(ra_mutex_pkg::CMD_REQUEST, any_id(), ra_mutex_pkg::SEQ_MAX);
    play_round();
    play_round();
    run_random(360);

    settle();
    write_id(any_id());
    wide_seq = 1'b0;
    run_random(390);

    settle();
    @(negedge clk);
    if (fail_total == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/ra_mutex_pkg.sv
src/ra_mutex_peer_ram.sv
src/ra_mutex_out_reg.sv
src/ra_mutex_ctrl.sv
src/ricart_agrawala_mutex_node.sv
verif/ricart_agrawala_mutex_node_checker.sv
verif/ricart_agrawala_mutex_node_test.sv
